// ===== hdl/drcm_pkg.sv =====
// ----------------------------------------------------------------------------
// drcm_pkg: shared types and constants for the delta-R cone child marker
// Child store sizing, angle widths, command codes and the ring cell record.
// ----------------------------------------------------------------------------
package drcm_pkg;

  // Store size and angle format
  localparam int MAX_CHILDREN = 64;
  localparam int PHI_BITS     = 11;
  localparam int ETA_W        = 12;
  localparam int PHI_IN_W     = 11;
  localparam int CONE_W       = 25;
  localparam int MASK_W       = 64;
  localparam int OUT_CNT_W    = 7;

  // Counter widths follow from the store size
  localparam int CNT_W  = $clog2(MAX_CHILDREN + 1);

  // Distance arithmetic widths
  localparam int AETA_W = ETA_W;
  localparam int ESQ_W  = 2 * AETA_W;
  localparam int PSQ_W  = 2 * PHI_BITS;
  localparam int DIST_W = ((ESQ_W > PSQ_W) ? ESQ_W : PSQ_W) + 1 > CONE_W ?
                          ((ESQ_W > PSQ_W) ? ESQ_W : PSQ_W) + 1 : CONE_W;

  localparam logic [PHI_BITS-1:0] PHI_HALF = PHI_BITS'(1) << (PHI_BITS - 1);

  // Cone register reset value
  localparam logic [CONE_W-1:0] CONE_RESET = CONE_W'(16900);

  // Command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_PARENT = 2'd1;
  localparam logic [1:0] CMD_EMIT   = 2'd2;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } drcm_state_t;

  // One stored child as it moves around the ring
  typedef struct packed {
    logic signed [ETA_W-1:0] eta;
    logic [PHI_BITS-1:0]     phi;
    logic                    mark;
  } drcm_child_t;

  // Cell controls driven by the controller
  typedef struct packed {
    logic shift_en;
    logic clr_mark;
  } drcm_cell_ctl_t;

endpackage

// ===== hdl/delta_r_cone_child_marker_unit.sv =====
// ----------------------------------------------------------------------------
// delta_r_cone_child_marker_unit: delta-R cone child marker, top level
// Children sit in a ring of cells; a kept parent rotates the ring once past
// a single squared-distance compare at the ring head, marking matches.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  command, eta, phi, parent_kept
//   out_     output     out_valid/out_ready child_keep_mask, child_count,
//                                          overflow
//   cfg_     input      cfg_valid/cfg_ready data (cone radius squared)
//
// Load, emit and unused commands do not turn the ring. A kept parent
// makes the ring one full turn, one child a cycle through the compare
// unit, before the next transaction is taken.
// Reset (rst_n low, synchronous) empties the store and the output register
// and sets the cone register to 16900. An emit waits while an earlier
// result is still held in the output register; other commands do not.
// ----------------------------------------------------------------------------
module delta_r_cone_child_marker_unit
  import drcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_command,
  input  logic signed [ETA_W-1:0] in_eta,
  input  logic [PHI_IN_W-1:0]     in_phi,
  input  logic                    in_parent_kept,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [MASK_W-1:0]       out_child_keep_mask,
  output logic [OUT_CNT_W-1:0]    out_child_count,
  output logic                    out_overflow,
  // Configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CONE_W-1:0]       cfg_data
);

  drcm_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]        step_r, step_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    flag_r, flag_nxt;
  logic [CONE_W-1:0]       cone_r;
  logic signed [ETA_W-1:0] par_eta_r;
  logic [PHI_BITS-1:0]     par_phi_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]       out_mask_r;
  logic [OUT_CNT_W-1:0]    out_count_r;
  logic                    out_ovf_r;

  logic                    in_fire;
  logic                    emit_fire;
  logic                    start_scan;
  logic                    scan_last;
  logic                    hit;
  logic                    head_valid;
  logic [PHI_BITS-1:0]     in_phi_w;
  logic [MASK_W-1:0]       marks_w;
  drcm_cell_ctl_t          cell_ctl;
  drcm_child_t             cell_q [MAX_CHILDREN];
  drcm_child_t             wrap_w;

  assign in_phi_w   = PHI_BITS'(in_phi);
  assign in_fire    = in_valid && in_ready;
  assign emit_fire  = in_fire && (in_command == CMD_EMIT);
  assign start_scan = in_fire && (in_command == CMD_PARENT) && in_parent_kept;
  assign scan_last  = (step_r == CNT_W'(MAX_CHILDREN - 1));
  assign cfg_ready  = 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_scan) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready          = 1'b0;
    cell_ctl.shift_en = 1'b0;
    cell_ctl.clr_mark = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !((in_command == CMD_EMIT) && out_valid_r && !out_ready);
        cell_ctl.clr_mark = emit_fire;
      end
      ST_SCAN: begin
        cell_ctl.shift_en = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Step counter over one ring turn
  always_comb begin
    step_nxt = step_r;
    if (start_scan) begin
      step_nxt = '0;
    end else if (state_r == ST_SCAN) begin
      step_nxt = step_r + CNT_W'(1);
    end
  end

  // Child count and drop flag
  always_comb begin
    count_nxt = count_r;
    flag_nxt  = flag_r;
    if (in_fire) begin
      case (in_command)
        CMD_LOAD: begin
          if (count_r == CNT_W'(MAX_CHILDREN)) begin
            flag_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_EMIT: begin
          count_nxt = '0;
          flag_nxt  = 1'b0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      flag_r      <= 1'b0;
      cone_r      <= CONE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cone_r <= cfg_data;
      end
    end
  end

  // Capture parent angles and result payload
  always_ff @(posedge clk) begin
    if (start_scan) begin
      par_eta_r <= in_eta;
      par_phi_r <= in_phi_w;
    end
    if (emit_fire) begin
      out_mask_r  <= marks_w;
      out_count_r <= OUT_CNT_W'(count_r);
      out_ovf_r   <= flag_r;
    end
  end

  // Compare the child at the ring head
  drcm_dist u_dist (
    .par_eta (par_eta_r),
    .par_phi (par_phi_r),
    .chd_eta (cell_q[0].eta),
    .chd_phi (cell_q[0].phi),
    .cone    (cone_r),
    .hit     (hit)
  );

  // Only loaded entries may be marked; head holds entry step_r
  assign head_valid  = (step_r < count_r);
  assign wrap_w.eta  = cell_q[0].eta;
  assign wrap_w.phi  = cell_q[0].phi;
  assign wrap_w.mark = cell_q[0].mark | (head_valid & hit);

  // Ring of child cells
  for (genvar k = 0; k < MAX_CHILDREN; k++) begin : g_cell
    drcm_child_t shift_in_w;
    logic        load_en_w;

    if (k == MAX_CHILDREN - 1) begin : g_tail
      assign shift_in_w = wrap_w;
    end else begin : g_body
      assign shift_in_w = cell_q[k+1];
    end

    assign load_en_w = in_fire && (in_command == CMD_LOAD) &&
                       (count_r == CNT_W'(k));

    drcm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .load_en  (load_en_w),
      .load_eta (in_eta),
      .load_phi (in_phi_w),
      .shift_in (shift_in_w),
      .q        (cell_q[k])
    );
  end

  // Gather mark bits into the keep mask
  for (genvar m = 0; m < MASK_W; m++) begin : g_mask
    if (m < MAX_CHILDREN) begin : g_used
      assign marks_w[m] = cell_q[m].mark;
    end else begin : g_unused
      assign marks_w[m] = 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_child_keep_mask = out_mask_r;
  assign out_child_count     = out_count_r;
  assign out_overflow        = out_ovf_r;

endmodule

// ===== hdl/drcm_cell.sv =====
// ----------------------------------------------------------------------------
// drcm_cell: one child slot of the rotating ring
// Holds one child angle pair and its mark bit; loads, clears or takes the
// neighbor's contents on a ring shift.
// ----------------------------------------------------------------------------
module drcm_cell
  import drcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  drcm_cell_ctl_t          ctl,
  input  logic                    load_en,
  input  logic signed [ETA_W-1:0] load_eta,
  input  logic [PHI_BITS-1:0]     load_phi,
  input  drcm_child_t             shift_in,
  output drcm_child_t             q
);

  logic signed [ETA_W-1:0] eta_r, eta_nxt;
  logic [PHI_BITS-1:0]     phi_r, phi_nxt;
  logic                    mark_r, mark_nxt;

  // Select shift, load or clear
  always_comb begin
    eta_nxt  = eta_r;
    phi_nxt  = phi_r;
    mark_nxt = mark_r;
    if (ctl.shift_en) begin
      eta_nxt  = shift_in.eta;
      phi_nxt  = shift_in.phi;
      mark_nxt = shift_in.mark;
    end else begin
      if (load_en) begin
        eta_nxt = load_eta;
        phi_nxt = load_phi;
      end
      if (ctl.clr_mark) begin
        mark_nxt = 1'b0;
      end
    end
  end

  // Hold angle data, no reset needed
  always_ff @(posedge clk) begin
    eta_r <= eta_nxt;
    phi_r <= phi_nxt;
  end

  // Mark bit clears on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= 1'b0;
    end else begin
      mark_r <= mark_nxt;
    end
  end

  assign q.eta  = eta_r;
  assign q.phi  = phi_r;
  assign q.mark = mark_r;

endmodule

// ===== hdl/drcm_dist.sv =====
// ----------------------------------------------------------------------------
// drcm_dist: squared delta-R compare
// Computes delta-eta squared plus wrapped delta-phi squared for the child at
// the ring head and compares it strictly below the cone register.
// ----------------------------------------------------------------------------
module drcm_dist
  import drcm_pkg::*;
(
  input  logic signed [ETA_W-1:0] par_eta,
  input  logic [PHI_BITS-1:0]     par_phi,
  input  logic signed [ETA_W-1:0] chd_eta,
  input  logic [PHI_BITS-1:0]     chd_phi,
  input  logic [CONE_W-1:0]       cone,
  output logic                    hit
);

  logic signed [ETA_W:0] de;
  logic [AETA_W-1:0]     ae;
  logic [PHI_BITS-1:0]   dp_raw;
  logic [PHI_BITS-1:0]   dp;
  logic [ESQ_W-1:0]      esq;
  logic [PSQ_W-1:0]      psq;
  logic [DIST_W-1:0]     dist_sum;

  // Absolute eta difference
  always_comb begin
    de = (ETA_W+1)'(par_eta) - (ETA_W+1)'(chd_eta);
    ae = de[ETA_W] ? AETA_W'(-de) : AETA_W'(de);
  end

  // Wrap phi difference to the short way around
  always_comb begin
    dp_raw = par_phi - chd_phi;
    dp     = (dp_raw > PHI_HALF) ? (PHI_BITS'(0) - dp_raw) : dp_raw;
  end

  // Square, sum and compare
  always_comb begin
    esq      = ESQ_W'(ae) * ESQ_W'(ae);
    psq      = PSQ_W'(dp) * PSQ_W'(dp);
    dist_sum = DIST_W'(esq) + DIST_W'(psq);
    hit      = dist_sum < DIST_W'(cone);
  end

endmodule
